/* rtl/core/apfd_pkg.sv */
`default_nettype none

package apfd_pkg;

    // Frame parse phases, one-hot
    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LEN_HI = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_CSUM   = 5'b10000
    } t_phase;

    // Registered input item handed from the input stage to the parser
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_in_item;

    localparam logic [7:0] DELIM_RESET = 8'h7E;
    // Sum of running sum and checksum (9 bits, no wrap) must hit this
    localparam logic [8:0] CSUM_TARGET = 9'h0FF;

endpackage

`default_nettype wire

/* rtl/core/apfd_in_stage.sv */
`default_nettype none

module apfd_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_take,
    output apfd_pkg::t_in_item     o_item
);
    import apfd_pkg::*;

    logic       r_vld;
    logic [7:0] r_data;
    logic       n_vld;

    // Hold the item until the parser takes it
    assign o_stall = r_vld && !i_take;

    always_comb begin
        n_vld = r_vld;
        if (!o_stall) begin
            n_vld = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_rx_byte;
        end
    end

    assign o_item.vld  = r_vld;
    assign o_item.data = r_data;

endmodule

`default_nettype wire

/* rtl/core/apfd_parse.sv */
`default_nettype none

module apfd_parse (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [7:0]          i_cfg_wr_data,
    input  wire apfd_pkg::t_in_item  i_item,
    output logic                     o_take,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [7:0]               o_out_byte,
    output logic [15:0]              o_byte_index,
    output logic                     o_frame_end,
    output logic                     o_checksum_good
);
    import apfd_pkg::*;

    logic [7:0]  r_delim;
    t_phase      r_phase,  n_phase;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_bytes_seen,   n_bytes_seen;
    logic [7:0]  r_running_sum,  n_running_sum;

    logic        r_out_valid;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic [15:0] r_out_index, n_out_index;
    logic        r_out_end,   n_out_end;
    logic        r_out_good,  n_out_good;
    logic        has_result;
    logic [15:0] seen_inc;
    logic [8:0]  csum_total;

    // Take an item when the result register is empty or draining
    assign o_take = i_item.vld && (!r_out_valid || !i_stall);

    assign seen_inc   = r_bytes_seen + 16'd1;
    assign csum_total = {1'b0, r_running_sum} + {1'b0, i_item.data};

    // Per-byte state update and result build
    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_bytes_seen   = r_bytes_seen;
        n_running_sum  = r_running_sum;
        has_result     = 1'b0;
        n_out_byte     = i_item.data;
        n_out_index    = r_bytes_seen;
        n_out_end      = 1'b0;
        n_out_good     = 1'b0;
        case (r_phase)
            PH_LEN_HI: begin
                n_frame_length = {i_item.data, 8'h00};
                n_phase        = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_frame_length = {r_frame_length[15:8], i_item.data};
                n_bytes_seen   = 16'd0;
                n_running_sum  = 8'd0;
                n_phase = ({r_frame_length[15:8], i_item.data} == 16'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
                has_result    = 1'b1;
                n_running_sum = r_running_sum + i_item.data;
                n_bytes_seen  = seen_inc;
                if (seen_inc == r_frame_length) begin
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                has_result  = 1'b1;
                n_out_index = r_frame_length;
                n_out_end   = 1'b1;
                n_out_good  = (csum_total == CSUM_TARGET);
                n_phase     = PH_HUNT;
            end
            default: begin
                n_phase = (i_item.data == r_delim) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim        <= DELIM_RESET;
            r_phase        <= PH_HUNT;
            r_frame_length <= 16'd0;
            r_bytes_seen   <= 16'd0;
            r_running_sum  <= 8'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_delim <= i_cfg_wr_data;
            end
            if (o_take) begin
                r_phase        <= n_phase;
                r_frame_length <= n_frame_length;
                r_bytes_seen   <= n_bytes_seen;
                r_running_sum  <= n_running_sum;
                r_out_valid    <= has_result;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_take && has_result) begin
            r_out_byte  <= n_out_byte;
            r_out_index <= n_out_index;
            r_out_end   <= n_out_end;
            r_out_good  <= n_out_good;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_byte_index    = r_out_index;
    assign o_frame_end     = r_out_end;
    assign o_checksum_good = r_out_good;

    // Hunt and length bytes never leave a result behind
    a_no_result_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (r_phase == PH_HUNT || r_phase == PH_LEN_HI || r_phase == PH_LEN_LO))
        |=> !r_out_valid)
        else $error("result produced for a header byte");

    // Data count stays below the frame length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bytes_seen < r_frame_length))
        else $error("data count reached frame length while in data phase");

    // A pending end-of-frame result means the parser is back to hunting
    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> (r_phase == PH_HUNT))
        else $error("end-of-frame pending outside hunt phase");

    // Data results carry the count seen before the byte
    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_phase == PH_DATA)
        |=> (r_out_valid && !r_out_end && r_out_index == $past(r_bytes_seen)))
        else $error("data result index mismatch");

endmodule

`default_nettype wire

/* rtl/core/api_frame_receive_deframer_unit.sv */
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+-----------------------------------------------
// rx in     | i_valid / o_stall    | i_rx_byte[7:0]
// result    | o_valid / i_stall    | o_out_byte, o_byte_index, o_frame_end,
//           |                      | o_checksum_good
// config    | i_cfg_wr_en          | i_cfg_wr_data[7:0] (delimiter)
//
// One item per cycle sustained while i_stall stays low; an accepted byte is held
// in the input register and then in the result register, where its result sits.
// Hunt and length bytes update state only and yield no result.
// Reset (synchronous, active low) returns to hunting with delimiter 0x7E.
// o_stall rises only when an item waits and a result is held by i_stall.

module api_frame_receive_deframer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic [15:0]      o_byte_index,
    output logic             o_frame_end,
    output logic             o_checksum_good
);
    import apfd_pkg::*;

    t_in_item item;
    logic     take;

    // Input register
    apfd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_take    (take),
        .o_item    (item)
    );

    // Frame parser and result register
    apfd_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_item          (item),
        .o_take          (take),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_index    (o_byte_index),
        .o_frame_end     (o_frame_end),
        .o_checksum_good (o_checksum_good)
    );

endmodule

`default_nettype wire
